// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the checker files.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

// ===== rtl/moia_pkg.sv =====
// Package for the multi-operation integer ALU: opcodes, widths, multiplier request and response types.
// Depends on nothing.
`timescale 1ns / 1ps
package moia_pkg;
  localparam int DATA_W    = 64;
  localparam int FRAC_BITS = 32;

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_SUB  = 4'd1,
    OP_MUL  = 4'd2,
    OP_DIV  = 4'd3,
    OP_FACT = 4'd4,
    OP_POW  = 4'd5,
    OP_AND  = 4'd6,
    OP_OR   = 4'd7,
    OP_XOR  = 4'd8
  } op_t;

  // Serial multiplier request: start pulse and the two factors.
  typedef struct packed {
    logic              go;
    logic [DATA_W-1:0] x;
    logic [DATA_W-1:0] y;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] p;
  } mul_rsp_t;
endpackage

// ===== rtl/moia_mul.sv =====
// Bit-serial shift-and-add multiplier, 64-bit product modulo 2^64.
// Depends on moia_pkg. One multiplier bit per cycle; stops early once the remaining multiplier bits are zero.
`timescale 1ns / 1ps
module moia_mul (
  input  logic               clk,
  input  logic               rst_n,
  input  moia_pkg::mul_req_t req,
  output moia_pkg::mul_rsp_t rsp
);
  import moia_pkg::*;

  logic [DATA_W-1:0] mcand_r, mcand_nxt, mplier_r, mplier_nxt, acc_r, acc_nxt;
  logic [6:0]        cnt_r, cnt_nxt;
  logic              run_r, run_nxt, done_r, done_nxt;

  always_comb begin
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    acc_nxt    = acc_r;
    cnt_nxt    = cnt_r;
    run_nxt    = run_r;
    done_nxt   = 1'b0;
    if (req.go) begin
      mcand_nxt  = req.x;
      mplier_nxt = req.y;
      acc_nxt    = '0;
      cnt_nxt    = 7'd0;
      run_nxt    = 1'b1;
    end else if (run_r) begin
      if (mplier_r[0]) acc_nxt = acc_r + mcand_r;
      mcand_nxt  = {mcand_r[DATA_W-2:0], 1'b0};
      mplier_nxt = {1'b0, mplier_r[DATA_W-1:1]};
      cnt_nxt    = cnt_r + 7'd1;
      if (cnt_r == 7'(DATA_W - 1) || mplier_nxt == '0) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    acc_r    <= acc_nxt;
    cnt_r    <= cnt_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.p    = acc_r;
endmodule

// ===== rtl/moia_div.sv =====
// Restoring divider, one quotient bit per cycle, for the signed fixed-point divide.
// Depends on moia_pkg. Magnitudes in, unsigned 128-bit quotient out.
`timescale 1ns / 1ps
module moia_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           go,
  input  logic [moia_pkg::DATA_W-1:0]    num,
  input  logic [moia_pkg::DATA_W-1:0]    den,
  output logic                           done,
  output logic [2*moia_pkg::DATA_W-1:0]  quo
);
  import moia_pkg::*;

  logic [2*DATA_W-1:0] sh_r, sh_nxt;
  logic [DATA_W:0]     rem_r, rem_nxt, trial;
  logic [DATA_W-1:0]   den_r, den_nxt;
  logic [7:0]          cnt_r, cnt_nxt;
  logic                run_r, run_nxt, done_r, done_nxt;

  // The shift register holds numerator bits on top and quotient bits below.
  always_comb begin
    sh_nxt   = sh_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    trial    = '0;
    if (go) begin
      sh_nxt  = {{DATA_W{1'b0}}, num} << FRAC_BITS;
      rem_nxt = '0;
      den_nxt = den;
      cnt_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      trial = {rem_r[DATA_W-1:0], sh_r[2*DATA_W-1]};
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        sh_nxt  = {sh_r[2*DATA_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        sh_nxt  = {sh_r[2*DATA_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 8'd1;
      if (cnt_r == 8'(2*DATA_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    sh_r  <= sh_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done = done_r;
  assign quo  = sh_r;
endmodule

// ===== rtl/multi_op_integer_alu_core.sv =====
// Top level of the multi-operation integer ALU: sequencer plus serial units.
// Depends on moia_pkg, moia_mul and moia_div.
`timescale 1ns / 1ps
// A request is taken when start is high and busy is low; the block then
// stays busy until it pulses out_valid for one cycle with the result. The
// receiver cannot stall, so the result must be captured in that cycle.
// Add, subtract and logic operations register the result when the request
// is taken and then pass through the output state. Multiply uses a
// bit-serial multiplier. Divide runs a restoring divider over 128 bits.
// Factorial runs up to 64 serial multiplies by a small factor. Power runs
// up to two multiplies per exponent bit. Multiply, factorial and power
// share the one multiplier.
module multi_op_integer_alu_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [3:0]                  in_mode,
  input  logic signed [moia_pkg::DATA_W-1:0] in_operand_a,
  input  logic signed [moia_pkg::DATA_W-1:0] in_operand_b,
  output logic                        out_valid,
  output logic signed [moia_pkg::DATA_W-1:0] out_result,
  output logic                        out_divide_by_zero,
  output logic                        out_saturated
);
  import moia_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MUL  = 7'b0000010,
    S_DIV  = 7'b0000100,
    S_FACT = 7'b0001000,
    S_PACC = 7'b0010000,
    S_PSQR = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t            st_r, st_nxt;
  logic [DATA_W-1:0] a_r, a_nxt, b_r, b_nxt, acc_r, acc_nxt;
  logic [DATA_W-1:0] res_r, res_nxt;
  logic [6:0]        k_r, k_nxt;
  logic              neg_r, neg_nxt, dz_r, dz_nxt, sat_r, sat_nxt, vld_r, vld_nxt;
  mul_req_t          mreq;
  mul_rsp_t          mrsp;
  logic              dgo, ddone;
  logic [2*DATA_W-1:0] dquo;
  logic [DATA_W-1:0] ua, ub, lim;
  logic              take;

  moia_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mreq), .rsp(mrsp));
  moia_div u_div (.clk(clk), .rst_n(rst_n), .go(dgo), .num(ua), .den(ub),
                  .done(ddone), .quo(dquo));

  assign take = start && (st_r == S_IDLE);
  assign ua   = in_operand_a[DATA_W-1] ? (~in_operand_a + 1'b1) : in_operand_a;
  assign ub   = in_operand_b[DATA_W-1] ? (~in_operand_b + 1'b1) : in_operand_b;
  assign lim  = neg_r ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};

  always_comb begin
    st_nxt   = st_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    res_nxt  = res_r;
    k_nxt    = k_r;
    neg_nxt  = neg_r;
    dz_nxt   = dz_r;
    sat_nxt  = sat_r;
    vld_nxt  = 1'b0;
    mreq     = '0;
    dgo      = 1'b0;
    unique case (st_r)
      S_IDLE: begin
        if (take) begin
          a_nxt    = in_operand_a;
          b_nxt    = in_operand_b;
          dz_nxt   = 1'b0;
          sat_nxt  = 1'b0;
          neg_nxt  = in_operand_a[DATA_W-1] ^ in_operand_b[DATA_W-1];
          st_nxt   = S_OUT;
          case (in_mode)
            OP_ADD: res_nxt = in_operand_a + in_operand_b;
            OP_SUB: res_nxt = in_operand_a - in_operand_b;
            OP_AND: res_nxt = in_operand_a & in_operand_b;
            OP_OR:  res_nxt = in_operand_a | in_operand_b;
            OP_XOR: res_nxt = in_operand_a ^ in_operand_b;
            OP_MUL: begin
              mreq   = '{go: 1'b1, x: in_operand_a, y: in_operand_b};
              st_nxt = S_MUL;
            end
            OP_DIV: begin
              if (in_operand_b == '0) begin
                res_nxt = '0;
                dz_nxt  = 1'b1;
              end else begin
                dgo    = 1'b1;
                st_nxt = S_DIV;
              end
            end
            OP_FACT: begin
              // Non-positive gives 1; 66 or more wraps to 0.
              if (in_operand_a[DATA_W-1] || in_operand_a < 64'sd2) begin
                res_nxt = 64'd1;
              end else if (in_operand_a >= 64'sd66) begin
                res_nxt = '0;
              end else begin
                acc_nxt = 64'd1;
                k_nxt   = 7'd2;
                mreq    = '{go: 1'b1, x: 64'd1, y: 64'd2};
                st_nxt  = S_FACT;
              end
            end
            OP_POW: begin
              if (in_operand_b[DATA_W-1] || in_operand_b == '0) begin
                res_nxt = 64'd1;
              end else begin
                acc_nxt = 64'd1;
                mreq    = '{go: 1'b1, x: 64'd1,
                            y: in_operand_b[0] ? in_operand_a : 64'd1};
                st_nxt  = S_PACC;
              end
            end
            default: res_nxt = '0;
          endcase
        end
      end
      S_MUL: begin
        if (mrsp.done) begin
          res_nxt = mrsp.p;
          st_nxt  = S_OUT;
        end
      end
      S_DIV: begin
        if (ddone) begin
          if (dquo[2*DATA_W-1:DATA_W] != '0 || dquo[DATA_W-1:0] > lim) begin
            sat_nxt = 1'b1;
            res_nxt = lim;
          end else begin
            res_nxt = neg_r ? (~dquo[DATA_W-1:0] + 1'b1) : dquo[DATA_W-1:0];
          end
          st_nxt = S_OUT;
        end
      end
      S_FACT: begin
        if (mrsp.done) begin
          if ({57'd0, k_r} == a_r) begin
            res_nxt = mrsp.p;
            st_nxt  = S_OUT;
          end else begin
            k_nxt = k_r + 7'd1;
            mreq  = '{go: 1'b1, x: mrsp.p, y: {57'd0, k_r + 7'd1}};
          end
        end
      end
      // Multiply accumulator by base when the exponent bit is set.
      S_PACC: begin
        if (mrsp.done) begin
          acc_nxt = mrsp.p;
          b_nxt   = {1'b0, b_r[DATA_W-1:1]};
          if (b_nxt == '0) begin
            res_nxt = mrsp.p;
            st_nxt  = S_OUT;
          end else begin
            mreq   = '{go: 1'b1, x: a_r, y: a_r};
            st_nxt = S_PSQR;
          end
        end
      end
      S_PSQR: begin
        if (mrsp.done) begin
          a_nxt  = mrsp.p;
          mreq   = '{go: 1'b1, x: acc_r, y: b_r[0] ? mrsp.p : 64'd1};
          st_nxt = S_PACC;
        end
      end
      S_OUT: begin
        vld_nxt = 1'b1;
        st_nxt  = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_IDLE;
      vld_r <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      vld_r <= vld_nxt;
    end
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    acc_r  <= acc_nxt;
    res_r  <= res_nxt;
    k_r    <= k_nxt;
    neg_r  <= neg_nxt;
    dz_r   <= dz_nxt;
    sat_r  <= sat_nxt;
  end

  assign busy               = (st_r != S_IDLE);
  assign out_valid          = vld_r;
  assign out_result         = res_r;
  assign out_divide_by_zero = dz_r;
  assign out_saturated      = sat_r;
endmodule

// ===== rtl/moia_checker.sv =====
// Port-level checker for the integer ALU, bound to the top level.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module moia_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input logic out_divide_by_zero,
  input logic out_saturated
);
  `ASSERT_NEXT(a_take_busy, clk, rst_n, start && !busy, busy)
  `ASSERT_IMPL(a_flags_excl, clk, rst_n, out_valid, !(out_divide_by_zero && out_saturated))
  `ASSERT_NEXT(a_valid_pulse, clk, rst_n, out_valid, !out_valid)
  `ASSERT_IMPL(a_valid_idle, clk, rst_n, out_valid, !busy)
endmodule

bind multi_op_integer_alu_core moia_checker u_chk (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_valid(out_valid),
  .out_divide_by_zero(out_divide_by_zero), .out_saturated(out_saturated));
